### sv/cld_pkg.sv
// Package with the types, constants and helper functions of the current limit derate unit.
`default_nettype none
package cld_pkg;

	// Factor value that means no derate, in 0.001 units.
	localparam logic [9:0] FACTOR_NONE = 10'd1000;
	// Reciprocal of 1000 scaled by 2**36, exact for every product below 2**26.
	localparam logic [26:0] SCALE_RECIP = 27'd68719477;
	// Shift that goes with the reciprocal.
	localparam int SCALE_SHIFT = 36;
	// Number of quotient bits, and so of pipeline stages, in the divider.
	localparam int DIV_STAGES = 16;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_VLOW_START  = 3'd0,
		CFG_VLOW_END    = 3'd1,
		CFG_VHIGH_START = 3'd2,
		CFG_VHIGH_END   = 3'd3,
		CFG_THIGH_START = 3'd4,
		CFG_THIGH_END   = 3'd5,
		CFG_FLOOR       = 3'd6,
		CFG_CHARGE_MODE = 3'd7
	} cfg_idx_t;

	// Which part of a ramp an input value falls on.
	typedef enum logic [1:0] {
		RSEL_LO  = 2'd0,
		RSEL_HI  = 2'd1,
		RSEL_MID = 2'd2
	} rsel_t;

	// One input item.
	typedef struct packed {
		logic [15:0]        min_cell_mv;
		logic [15:0]        max_cell_mv;
		logic signed [15:0] max_temp_dc;
		logic [15:0]        discharge_table_da;
		logic [15:0]        regen_table_da;
		logic [15:0]        charge_table_da;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [9:0]  discharge_factor;
		logic [9:0]  charge_side_factor;
		logic [15:0] discharge_final_da;
		logic [15:0] regen_final_da;
		logic [15:0] charge_final_da;
		logic        vlow_active;
		logic        vhigh_active;
		logic        thigh_active;
		logic        mode_out;
	} result_t;

	// Configuration register file.
	typedef struct packed {
		logic [15:0] vlow_start_mv;
		logic [15:0] vlow_end_mv;
		logic [15:0] vhigh_start_mv;
		logic [15:0] vhigh_end_mv;
		logic [10:0] thigh_start_dc;
		logic [10:0] thigh_end_dc;
		logic [9:0]  derate_floor;
		logic        charge_mode;
	} cfg_t;

	// A classified ramp before the multiply.
	typedef struct packed {
		rsel_t       sel;
		logic        down;
		logic [9:0]  yl;
		logic [9:0]  yh;
		logic [9:0]  dy;
		logic [15:0] dx;
		logic [15:0] span;
	} ramp_t;

	// What the back part needs of a ramp besides its quotient.
	typedef struct packed {
		rsel_t      sel;
		logic       down;
		logic [9:0] yl;
		logic [9:0] yh;
	} ramp_sb_t;

	// A ramp as it waits in the queue.
	typedef struct packed {
		ramp_sb_t    sb;
		logic [25:0] prod;
		logic [15:0] span;
	} qramp_t;

	// One queue entry.
	typedef struct packed {
		qramp_t      r_vlow;
		qramp_t      r_vhigh;
		qramp_t      r_temp;
		logic [15:0] discharge_table_da;
		logic [15:0] regen_table_da;
		logic [15:0] charge_table_da;
		logic        mode;
	} qent_t;

	// Sideband that travels beside the ramp dividers.
	typedef struct packed {
		ramp_sb_t    r_vlow;
		ramp_sb_t    r_vhigh;
		ramp_sb_t    r_temp;
		logic [15:0] discharge_table_da;
		logic [15:0] regen_table_da;
		logic [15:0] charge_table_da;
		logic        mode;
	} sb1_t;

	// Sideband that travels beside the limit scaling.
	typedef struct packed {
		logic [9:0] k_dis;
		logic [9:0] k_chg;
		logic       vlow_active;
		logic       vhigh_active;
		logic       thigh_active;
		logic       mode;
	} sb2_t;

	// Classify x against the breakpoints (xl, yl) and (xh, yh).
	function automatic ramp_t ramp_prep(input logic [15:0] x, input logic [15:0] xl,
			input logic [9:0] yl, input logic [15:0] xh, input logic [9:0] yh);
		ramp_t r;
		r.yl   = yl;
		r.yh   = yh;
		r.down = (yh < yl);
		r.dy   = r.down ? (yl - yh) : (yh - yl);
		r.dx   = x - xl;
		r.span = xh - xl;
		if (x <= xl) begin
			r.sel = RSEL_LO;
		end else if (x >= xh) begin
			r.sel = RSEL_HI;
		end else begin
			r.sel = RSEL_MID;
		end
		return r;
	endfunction

	// Pick the ramp's value once the interpolation quotient is known.
	function automatic logic [9:0] ramp_finish(input ramp_sb_t s, input logic [9:0] q);
		logic [9:0] k;
		case (s.sel)
			RSEL_LO:  k = s.yl;
			RSEL_HI:  k = s.yh;
			RSEL_MID: k = s.down ? (s.yl - q) : (s.yl + q);
			default:  k = s.yl;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

### sv/cld_div.sv
// Pipelined restoring divider, one quotient bit per stage, for quotients below 2**16.
`default_nettype none
module cld_div (
	input  wire logic        clk,
	input  wire logic [25:0] dividend,
	input  wire logic [15:0] divisor,
	output logic      [15:0] quotient
);

	localparam int N = cld_pkg::DIV_STAGES;

	logic [15:0] rem_s [1:N];
	logic [15:0] low_s [1:N];
	logic [15:0] dvs_s [1:N];
	logic [15:0] quo_s [1:N];

	genvar k;
	generate
		for (k = 1; k <= N; k++) begin : g_stage
			logic [15:0] rem_in;
			logic [15:0] low_in;
			logic [15:0] dvs_in;
			logic [15:0] quo_in;
			logic [16:0] trial;
			logic        ge;

			// The first stage starts from the top bits, which stay below the divisor.
			if (k == 1) begin : g_first
				assign rem_in = 16'(dividend[25:16]);
				assign low_in = dividend[15:0];
				assign dvs_in = divisor;
				assign quo_in = '0;
			end else begin : g_next
				assign rem_in = rem_s[k-1];
				assign low_in = low_s[k-1];
				assign dvs_in = dvs_s[k-1];
				assign quo_in = quo_s[k-1];
			end

			// Shift in the next dividend bit and subtract where it fits.
			assign trial = {rem_in, low_in[15]};
			assign ge    = (trial >= {1'b0, dvs_in});

			always_ff @(posedge clk) begin
				rem_s[k] <= ge ? 16'(trial - {1'b0, dvs_in}) : trial[15:0];
				low_s[k] <= {low_in[14:0], 1'b0};
				dvs_s[k] <= dvs_in;
				quo_s[k] <= {quo_in[14:0], ge};
			end
		end
	endgenerate

	assign quotient = quo_s[N];

endmodule
`default_nettype wire

### sv/cld_front.sv
// Front part: configuration registers, item accept, ramp classification and multiply.
`default_nettype none
module cld_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           busy,
	input  wire cld_pkg::item_t item,
	input  wire logic           cfg_we,
	input  wire logic [2:0]     cfg_index,
	input  wire logic [15:0]    cfg_data,
	output logic                push,
	output cld_pkg::qent_t      push_data
);

	cld_pkg::cfg_t  cfg_q;
	logic [9:0]     fl;
	logic [15:0]    temp_x;
	logic           accept;
	logic           v_s1;
	cld_pkg::ramp_t r_vlow_s1;
	cld_pkg::ramp_t r_vhigh_s1;
	cld_pkg::ramp_t r_temp_s1;
	cld_pkg::item_t item_s1;
	logic           mode_s1;
	logic           v_s2;
	cld_pkg::qent_t q_s2;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vlow_start_mv  <= 16'd3300;
			cfg_q.vlow_end_mv    <= 16'd3000;
			cfg_q.vhigh_start_mv <= 16'd4100;
			cfg_q.vhigh_end_mv   <= 16'd4200;
			cfg_q.thigh_start_dc <= 11'd450;
			cfg_q.thigh_end_dc   <= 11'd600;
			cfg_q.derate_floor   <= 10'd100;
			cfg_q.charge_mode    <= 1'b0;
		end else if (cfg_we) begin
			case (cld_pkg::cfg_idx_t'(cfg_index))
				cld_pkg::CFG_VLOW_START:  cfg_q.vlow_start_mv  <= cfg_data;
				cld_pkg::CFG_VLOW_END:    cfg_q.vlow_end_mv    <= cfg_data;
				cld_pkg::CFG_VHIGH_START: cfg_q.vhigh_start_mv <= cfg_data;
				cld_pkg::CFG_VHIGH_END:   cfg_q.vhigh_end_mv   <= cfg_data;
				cld_pkg::CFG_THIGH_START: cfg_q.thigh_start_dc <= cfg_data[10:0];
				cld_pkg::CFG_THIGH_END:   cfg_q.thigh_end_dc   <= cfg_data[10:0];
				cld_pkg::CFG_FLOOR:       cfg_q.derate_floor   <= cfg_data[9:0];
				cld_pkg::CFG_CHARGE_MODE: cfg_q.charge_mode    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Floors above full scale count as full scale.
	assign fl = (cfg_q.derate_floor > cld_pkg::FACTOR_NONE) ? cld_pkg::FACTOR_NONE
		: cfg_q.derate_floor;

	// A temperature at or below zero maps to zero, which is never above the start point.
	assign temp_x = (item.max_temp_dc[15] || (item.max_temp_dc == 16'sd0)) ? 16'd0
		: item.max_temp_dc;

	assign accept = start && !busy;

	// Stage one classifies each ramp.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		r_vlow_s1  <= cld_pkg::ramp_prep(item.min_cell_mv, cfg_q.vlow_end_mv, fl,
			cfg_q.vlow_start_mv, cld_pkg::FACTOR_NONE);
		r_vhigh_s1 <= cld_pkg::ramp_prep(item.max_cell_mv, cfg_q.vhigh_start_mv,
			cld_pkg::FACTOR_NONE, cfg_q.vhigh_end_mv, fl);
		r_temp_s1  <= cld_pkg::ramp_prep(temp_x, 16'(cfg_q.thigh_start_dc),
			cld_pkg::FACTOR_NONE, 16'(cfg_q.thigh_end_dc), fl);
		item_s1    <= item;
		mode_s1    <= cfg_q.charge_mode;
	end

	// Stage two forms the ramp products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		q_s2.r_vlow.sb  <= '{r_vlow_s1.sel, r_vlow_s1.down, r_vlow_s1.yl, r_vlow_s1.yh};
		q_s2.r_vlow.prod <= 26'(r_vlow_s1.dy) * 26'(r_vlow_s1.dx);
		q_s2.r_vlow.span <= r_vlow_s1.span;
		q_s2.r_vhigh.sb <= '{r_vhigh_s1.sel, r_vhigh_s1.down, r_vhigh_s1.yl, r_vhigh_s1.yh};
		q_s2.r_vhigh.prod <= 26'(r_vhigh_s1.dy) * 26'(r_vhigh_s1.dx);
		q_s2.r_vhigh.span <= r_vhigh_s1.span;
		q_s2.r_temp.sb  <= '{r_temp_s1.sel, r_temp_s1.down, r_temp_s1.yl, r_temp_s1.yh};
		q_s2.r_temp.prod <= 26'(r_temp_s1.dy) * 26'(r_temp_s1.dx);
		q_s2.r_temp.span <= r_temp_s1.span;
		q_s2.discharge_table_da <= item_s1.discharge_table_da;
		q_s2.regen_table_da     <= item_s1.regen_table_da;
		q_s2.charge_table_da    <= item_s1.charge_table_da;
		q_s2.mode               <= mode_s1;
	end

	assign push      = v_s2;
	assign push_data = q_s2;

endmodule
`default_nettype wire

### sv/cld_queue.sv
// Two-entry queue between the front and back parts.
`default_nettype none
module cld_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire cld_pkg::qent_t push_data,
	input  wire logic           pop,
	output logic                valid,
	output cld_pkg::qent_t      pop_data,
	output logic                full
);

	cld_pkg::qent_t mem_q [0:1];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;

	assign valid   = (count_q != 2'd0);
	assign full    = (count_q == 2'd2);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule
`default_nettype wire

### sv/cld_back.sv
// Back part: ramp division, factor selection, limit scaling and mode gating.
`default_nettype none
module cld_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           valid,
	input  wire cld_pkg::qent_t pop_data,
	output logic                pop,
	output logic                done,
	output cld_pkg::result_t    result
);

	localparam int N = cld_pkg::DIV_STAGES;

	logic [15:0]       q_vlow;
	logic [15:0]       q_vhigh;
	logic [15:0]       q_temp;
	logic              v1_s [0:N-1];
	cld_pkg::sb1_t     sb1_s [0:N-1];
	logic [9:0]        k_vlow;
	logic [9:0]        k_vhigh;
	logic [9:0]        k_temp;
	logic              v_c;
	cld_pkg::sb2_t     c_c;
	cld_pkg::sb1_t     tab_c;
	logic              v_m;
	cld_pkg::sb2_t     c_m;
	logic [25:0]       p_dis_m;
	logic [25:0]       p_reg_m;
	logic [25:0]       p_chg_m;
	logic [52:0]       sp_dis;
	logic [52:0]       sp_reg;
	logic [52:0]       sp_chg;
	logic              v_sc;
	cld_pkg::sb2_t     c_sc;
	logic [15:0]       f_dis_sc;
	logic [15:0]       f_reg_sc;
	logic [15:0]       f_chg_sc;
	logic              done_q;
	cld_pkg::result_t  result_q;

	// The back part drains the queue every cycle.
	assign pop = valid;

	// Ramp interpolation dividers.
	cld_div u_div_vlow (.clk(clk), .dividend(pop_data.r_vlow.prod),
		.divisor(pop_data.r_vlow.span), .quotient(q_vlow));
	cld_div u_div_vhigh (.clk(clk), .dividend(pop_data.r_vhigh.prod),
		.divisor(pop_data.r_vhigh.span), .quotient(q_vhigh));
	cld_div u_div_temp (.clk(clk), .dividend(pop_data.r_temp.prod),
		.divisor(pop_data.r_temp.span), .quotient(q_temp));

	// Sideband and valid line beside the ramp dividers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				v1_s[i] <= 1'b0;
			end
		end else begin
			v1_s[0] <= valid;
			for (int i = 1; i < N; i++) begin
				v1_s[i] <= v1_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		sb1_s[0] <= '{pop_data.r_vlow.sb, pop_data.r_vhigh.sb, pop_data.r_temp.sb,
			pop_data.discharge_table_da, pop_data.regen_table_da,
			pop_data.charge_table_da, pop_data.mode};
		for (int i = 1; i < N; i++) begin
			sb1_s[i] <= sb1_s[i-1];
		end
	end

	// Finish the ramps and take the smaller factors.
	assign k_vlow  = cld_pkg::ramp_finish(sb1_s[N-1].r_vlow, q_vlow[9:0]);
	assign k_vhigh = cld_pkg::ramp_finish(sb1_s[N-1].r_vhigh, q_vhigh[9:0]);
	assign k_temp  = cld_pkg::ramp_finish(sb1_s[N-1].r_temp, q_temp[9:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c  <= 1'b0;
			v_m  <= 1'b0;
			v_sc <= 1'b0;
		end else begin
			v_c  <= v1_s[N-1];
			v_m  <= v_c;
			v_sc <= v_m;
		end
	end

	always_ff @(posedge clk) begin
		c_c.k_dis        <= (k_vlow < k_temp) ? k_vlow : k_temp;
		c_c.k_chg        <= (k_vhigh < k_temp) ? k_vhigh : k_temp;
		c_c.vlow_active  <= (k_vlow < cld_pkg::FACTOR_NONE);
		c_c.vhigh_active <= (k_vhigh < cld_pkg::FACTOR_NONE);
		c_c.thigh_active <= (k_temp < cld_pkg::FACTOR_NONE);
		c_c.mode         <= sb1_s[N-1].mode;
		tab_c            <= sb1_s[N-1];
	end

	// Multiply each static limit by its factor.
	always_ff @(posedge clk) begin
		c_m     <= c_c;
		p_dis_m <= 26'(tab_c.discharge_table_da) * 26'(c_c.k_dis);
		p_reg_m <= 26'(tab_c.regen_table_da) * 26'(c_c.k_chg);
		p_chg_m <= 26'(tab_c.charge_table_da) * 26'(c_c.k_chg);
	end

	// Scale the products back to 0.1 A by a reciprocal multiply of 1/1000.
	assign sp_dis = 53'(p_dis_m) * 53'(cld_pkg::SCALE_RECIP);
	assign sp_reg = 53'(p_reg_m) * 53'(cld_pkg::SCALE_RECIP);
	assign sp_chg = 53'(p_chg_m) * 53'(cld_pkg::SCALE_RECIP);

	always_ff @(posedge clk) begin
		c_sc     <= c_m;
		f_dis_sc <= sp_dis[cld_pkg::SCALE_SHIFT +: 16];
		f_reg_sc <= sp_reg[cld_pkg::SCALE_SHIFT +: 16];
		f_chg_sc <= sp_chg[cld_pkg::SCALE_SHIFT +: 16];
	end

	// Output register with mode gating.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_sc;
		end
	end

	always_ff @(posedge clk) begin
		result_q.discharge_factor   <= c_sc.k_dis;
		result_q.charge_side_factor <= c_sc.k_chg;
		result_q.discharge_final_da <= c_sc.mode ? 16'd0 : f_dis_sc;
		result_q.regen_final_da     <= c_sc.mode ? 16'd0 : f_reg_sc;
		result_q.charge_final_da    <= c_sc.mode ? f_chg_sc : 16'd0;
		result_q.vlow_active        <= c_sc.vlow_active;
		result_q.vhigh_active       <= c_sc.vhigh_active;
		result_q.thigh_active       <= c_sc.thigh_active;
		result_q.mode_out           <= c_sc.mode;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

### sv/current_limit_derate_unit.sv
// Top level of the current limit derate unit.
//
// An item (cell voltage extremes, peak temperature and three static current
// limits) is taken at a rising edge with start high and busy low. The front
// part classifies the three derate ramps and forms their products, then
// hands the item through a two-entry queue to the back part, which divides,
// picks the smaller factors, scales the limits and gates them by mode.
// One item can be taken every cycle; the back part drains the queue every
// cycle, so busy stays low in use.
// Each result shows on result for exactly one cycle with done high, after its
// item passes two front stages, one queue stage, a 16-stage bit-per-cycle
// ramp divider, the factor register, the limit multiply, the reciprocal
// scaling and the output register.
// The receiver cannot stall the results.
// Registers are written through cfg_we, cfg_index and cfg_data; write them
// only while idle; the block itself does not enforce this. Reset clears the
// pipeline valid bits and the queue and loads the register defaults.
`default_nettype none
module current_limit_derate_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire cld_pkg::item_t item,
	output logic                done,
	output cld_pkg::result_t    result,
	input  wire logic           cfg_we,
	input  wire logic [2:0]     cfg_index,
	input  wire logic [15:0]    cfg_data
);

	logic           push;
	cld_pkg::qent_t push_data;
	logic           q_valid;
	cld_pkg::qent_t pop_data;
	logic           pop;

	cld_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .push_data(push_data)
	);

	cld_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.pop(pop), .valid(q_valid), .pop_data(pop_data), .full(busy)
	);

	cld_back u_back (
		.clk(clk), .arst_n(arst_n), .valid(q_valid), .pop_data(pop_data),
		.pop(pop), .done(done), .result(result)
	);

endmodule
`default_nettype wire

### sv/cld_checker.sv
// Port checker for the current limit derate unit and its bind.
`default_nettype none
module cld_port_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             busy,
	input wire logic             done,
	input wire cld_pkg::result_t result
);

	// The queue never fills, so items are never held off.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// Factors stay within full scale.
	a_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.discharge_factor <= 10'd1000) &&
			(result.charge_side_factor <= 10'd1000))
		else $error("factor above full scale");

	// Charge mode zeroes discharge and regen limits.
	a_charge_gate: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.mode_out |-> (result.discharge_final_da == 16'd0) &&
			(result.regen_final_da == 16'd0))
		else $error("discharge side not gated in charge mode");

	// Discharge mode zeroes the charge limit.
	a_discharge_gate: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.mode_out |-> (result.charge_final_da == 16'd0))
		else $error("charge limit not gated in discharge mode");

	// With no derate active the discharge factor is full scale.
	a_no_derate: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.vlow_active && !result.thigh_active |->
			(result.discharge_factor == 10'd1000))
		else $error("discharge factor derated without cause");

endmodule

bind current_limit_derate_unit cld_port_checker u_cld_checker (
	.clk(clk), .arst_n(arst_n), .busy(busy), .done(done), .result(result)
);
`default_nettype wire
